>>> design/sspc_pkg.sv
// Package for the servo status packet checker.
// Holds the result codes, register indexes and the structs passed between the
// front, queue and back stages. No dependencies.
package sspc_pkg;

    localparam int BYTE_W     = 8;
    localparam int STATUS_W   = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam int PCOUNT_W   = 6;
    // wide enough for any parameter count up to 64
    localparam int NCNT_W     = 7;
    localparam int SIDX_W     = 6;

    localparam logic [BYTE_W-1:0] HDR_BYTE  = 8'hFF;
    localparam int                ID_POS    = 2;
    localparam int                ERR_POS   = 4;
    localparam int                PARAM_POS = 5;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 3'd0,
        ST_SHORT        = 3'd1,
        ST_BAD_HEADER   = 3'd2,
        ST_WRONG_ID     = 3'd3,
        ST_BAD_CHECKSUM = 3'd4
    } status_t;

    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_END  = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EXPECTED_ID = 1'b0,
        REG_PARAM_COUNT = 1'b1
    } reg_idx_t;

    // One report for the back stage.
    typedef struct packed {
        status_t             status;
        logic [BYTE_W-1:0]   servo_error;
        logic [NCNT_W-1:0]   count;
        logic                bank;
    } cmd_t;

    typedef struct packed {
        logic                valid;
        logic                bank;
        logic [SIDX_W-1:0]   idx;
        logic [BYTE_W-1:0]   data;
    } store_wr_t;

    typedef struct packed {
        logic valid;
        logic bank;
    } busy_clr_t;

endpackage

>>> design/sspc_in_if.sv
// Input channel of the servo status packet checker: one bus byte or an
// end-of-response mark per item. Depends on sspc_pkg.
interface sspc_in_if import sspc_pkg::*;;
    logic              valid;
    logic              ready;
    logic              op;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output op, output rx_byte, input ready);
    modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

>>> design/sspc_out_if.sv
// Output channel of the servo status packet checker: one status or replayed
// parameter per item. Depends on sspc_pkg.
interface sspc_out_if import sspc_pkg::*;;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   servo_error;
    logic [BYTE_W-1:0]   data_byte;
    logic                has_data;
    logic                last;

    modport source (output valid, output status, output servo_error, output data_byte,
                    output has_data, output last, input ready);
    modport sink   (input valid, input status, input servo_error, input data_byte,
                    input has_data, input last, output ready);
endinterface

>>> design/sspc_queue.sv
// Two-entry report queue between the front and back stages.
// Depends on sspc_pkg.
module sspc_queue import sspc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output logic full,
    output logic empty,
    output cmd_t head
);

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full  = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("report queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("report queue underflow");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg != 2'd3)
        else $error("report queue count out of range");
`endif

endmodule

>>> design/sspc_front.sv
// Front stage: takes bus bytes, checks header, id and checksum, writes the
// parameter bytes into the store and queues one report per packet.
// Depends on sspc_pkg and sspc_in_if.
module sspc_front import sspc_pkg::*;
#(
    parameter int MAX_PARAMS = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [BYTE_W-1:0]   expected_id,
    input  logic [PCOUNT_W-1:0] param_count,
    sspc_in_if.sink             in_ch,
    input  logic                q_full,
    output logic                q_push,
    output cmd_t                q_cmd,
    output store_wr_t           store_wr,
    input  busy_clr_t           busy_clr
);

    localparam int                CNT_W = $clog2(MAX_PARAMS + PARAM_POS + 2);
    localparam logic [NCNT_W-1:0] MAX_N = NCNT_W'(MAX_PARAMS);

    logic [CNT_W-1:0]  byte_count_reg, byte_count_next;
    logic [BYTE_W-1:0] sum_reg, sum_next;
    logic              header_bad_reg, header_bad_next;
    logic              id_bad_reg, id_bad_next;
    logic [BYTE_W-1:0] err_reg, err_next;
    logic [1:0]        busy_reg, busy_next;
    logic              wbank_reg, wbank_next;

    logic [NCNT_W-1:0] n;
    logic [CNT_W-1:0]  limit;
    logic [CNT_W-1:0]  pidx;
    logic              in_param;
    logic              fire;
    logic              pkt_done;
    logic              good;

    always_comb
    begin
        n        = (NCNT_W'(param_count) > MAX_N) ? MAX_N : NCNT_W'(param_count);
        limit    = CNT_W'(n) + CNT_W'(PARAM_POS);
        pidx     = byte_count_reg - CNT_W'(PARAM_POS);
        in_param = (byte_count_reg >= CNT_W'(PARAM_POS)) && (byte_count_reg < limit);
        in_ch.ready = !q_full && !(in_param && busy_reg[wbank_reg]);
        fire     = in_ch.valid && in_ch.ready;
    end

    always_comb
    begin
        byte_count_next = byte_count_reg;
        sum_next        = sum_reg;
        header_bad_next = header_bad_reg;
        id_bad_next     = id_bad_reg;
        err_next        = err_reg;
        busy_next       = busy_reg;
        wbank_next      = wbank_reg;
        q_push          = 1'b0;
        q_cmd           = '{status: ST_OK, servo_error: '0, count: '0, bank: wbank_reg};
        store_wr        = '{valid: 1'b0, bank: wbank_reg, idx: SIDX_W'(pidx),
                            data: in_ch.rx_byte};
        pkt_done        = 1'b0;
        good            = 1'b0;

        if (busy_clr.valid)
        begin
            busy_next[busy_clr.bank] = 1'b0;
        end

        if (fire)
        begin
            if (in_ch.op == OP_END)
            begin
                if (byte_count_reg != '0)
                begin
                    q_push       = 1'b1;
                    q_cmd.status = ST_SHORT;
                    pkt_done     = 1'b1;
                end
            end
            else if (byte_count_reg < limit)
            begin
                if (byte_count_reg < CNT_W'(ID_POS))
                begin
                    if (in_ch.rx_byte != HDR_BYTE)
                    begin
                        header_bad_next = 1'b1;
                    end
                end
                else
                begin
                    if (byte_count_reg == CNT_W'(ID_POS))
                    begin
                        id_bad_next = (in_ch.rx_byte != expected_id);
                    end
                    else if (byte_count_reg == CNT_W'(ERR_POS))
                    begin
                        err_next = in_ch.rx_byte;
                    end
                    else if (byte_count_reg >= CNT_W'(PARAM_POS))
                    begin
                        store_wr.valid = 1'b1;
                    end
                    sum_next = sum_reg + in_ch.rx_byte;
                end
                byte_count_next = byte_count_reg + 1'b1;
            end
            else
            begin
                q_push   = 1'b1;
                pkt_done = 1'b1;
                if (header_bad_reg)
                begin
                    q_cmd.status = ST_BAD_HEADER;
                end
                else if (id_bad_reg)
                begin
                    q_cmd.status = ST_WRONG_ID;
                end
                else if (~sum_reg != in_ch.rx_byte)
                begin
                    q_cmd.status = ST_BAD_CHECKSUM;
                end
                else
                begin
                    good              = 1'b1;
                    q_cmd.servo_error = err_reg;
                    q_cmd.count       = n;
                end
                if (good && (n != '0))
                begin
                    busy_next[wbank_reg] = 1'b1;
                    wbank_next           = ~wbank_reg;
                end
            end

            if (pkt_done)
            begin
                byte_count_next = '0;
                sum_next        = '0;
                header_bad_next = 1'b0;
                id_bad_next     = 1'b0;
                err_next        = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            sum_reg        <= '0;
            header_bad_reg <= 1'b0;
            id_bad_reg     <= 1'b0;
            err_reg        <= '0;
            busy_reg       <= '0;
            wbank_reg      <= 1'b0;
        end
        else
        begin
            byte_count_reg <= byte_count_next;
            sum_reg        <= sum_next;
            header_bad_reg <= header_bad_next;
            id_bad_reg     <= id_bad_next;
            err_reg        <= err_next;
            busy_reg       <= busy_next;
            wbank_reg      <= wbank_next;
        end
    end

`ifndef SYNTHESIS
    a_wr_free_bank: assert property (@(posedge clk) disable iff (!rst_n)
        store_wr.valid |-> !busy_reg[store_wr.bank])
        else $error("parameter write into a bank still being replayed");
    a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
        pkt_done |=> (byte_count_reg == '0) && (sum_reg == '0))
        else $error("packet state not cleared after report");
    a_push_space: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full && fire)
        else $error("report pushed without an accepted item or queue space");
`endif

endmodule

>>> design/sspc_back.sv
// Back stage: holds the two-bank parameter store, pops reports and drives
// the output register, replaying stored parameters one per item.
// Depends on sspc_pkg and sspc_out_if.
module sspc_back import sspc_pkg::*;
#(
    parameter int MAX_PARAMS = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_empty,
    input  cmd_t      q_head,
    output logic      q_pop,
    input  store_wr_t store_wr,
    output busy_clr_t busy_clr,
    sspc_out_if.source out_ch
);

    localparam int                IDX_W  = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
    localparam int                ADDR_W = IDX_W + 1;
    localparam logic [NCNT_W-1:0] MAX_N  = NCNT_W'(MAX_PARAMS);

    logic [BYTE_W-1:0] mem [0:(1 << ADDR_W)-1];

    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              out_valid_reg, out_valid_next;
    status_t           status_reg;
    logic [BYTE_W-1:0] err_reg;
    logic              has_data_reg;
    logic              last_reg;
    logic [BYTE_W-1:0] rd_data_reg;

    logic emit;
    logic replay;
    logic last_item;

    always_comb
    begin
        emit      = !q_empty && (!out_valid_reg || out_ch.ready);
        replay    = (q_head.status == ST_OK) && (q_head.count != '0);
        last_item = !replay || ((NCNT_W'(idx_reg) + NCNT_W'(1)) == q_head.count);
        q_pop     = emit && last_item;
        busy_clr  = '{valid: emit && replay && last_item, bank: q_head.bank};

        idx_next = idx_reg;
        if (emit && replay)
        begin
            idx_next = last_item ? '0 : idx_reg + 1'b1;
        end

        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            status_reg   <= q_head.status;
            err_reg      <= q_head.servo_error;
            has_data_reg <= replay;
            last_reg     <= last_item;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_wr.valid)
        begin
            mem[{store_wr.bank, store_wr.idx[IDX_W-1:0]}] <= store_wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit && replay)
        begin
            rd_data_reg <= mem[{q_head.bank, idx_reg}];
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.status      = status_reg;
    assign out_ch.servo_error = err_reg;
    assign out_ch.data_byte   = has_data_reg ? rd_data_reg : '0;
    assign out_ch.has_data    = has_data_reg;
    assign out_ch.last        = last_reg;

`ifndef SYNTHESIS
    a_data_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && has_data_reg |-> status_reg == ST_OK)
        else $error("parameter byte with a failing status");
    a_idx_rewind: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> idx_reg == '0)
        else $error("replay index not rewound after report");
    a_count_fits: assert property (@(posedge clk) disable iff (!rst_n)
        emit && replay |-> q_head.count <= MAX_N)
        else $error("replay count exceeds store size");
`endif

endmodule

>>> design/servo_status_packet_checker_top.sv
// Servo status packet checker, top level. Configuration registers and the
// front / queue / back stages. Depends on sspc_pkg, sspc_in_if, sspc_out_if.
//
// Takes one bus byte (or end-of-response mark) per cycle. The front checks
// header, id and checksum and writes parameter bytes into one of two store
// banks; the result item for a completed packet passes through the report
// queue into the output register, and a good packet with n parameters then
// replays one byte per cycle while the output is not held off. Input stalls
// only when the two-entry report queue is full, or when a parameter byte
// would land in the bank whose replay is still waiting on the output side.
// Write configuration only while no packet is in progress.
module servo_status_packet_checker_top import sspc_pkg::*;
#(
    parameter int MAX_PARAMS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    sspc_in_if.sink               in_ch,
    sspc_out_if.source            out_ch
);

    logic [BYTE_W-1:0]   expected_id_reg;
    logic [PCOUNT_W-1:0] param_count_reg;

    logic      q_full;
    logic      q_empty;
    logic      q_push;
    logic      q_pop;
    cmd_t      q_cmd;
    cmd_t      q_head;
    store_wr_t store_wr;
    busy_clr_t busy_clr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_id_reg <= 8'd1;
            param_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_EXPECTED_ID: expected_id_reg <= cfg_wdata;
                REG_PARAM_COUNT: param_count_reg <= cfg_wdata[PCOUNT_W-1:0];
                default:         ;
            endcase
        end
    end

    sspc_front #(
        .MAX_PARAMS (MAX_PARAMS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .expected_id (expected_id_reg),
        .param_count (param_count_reg),
        .in_ch       (in_ch),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_cmd       (q_cmd),
        .store_wr    (store_wr),
        .busy_clr    (busy_clr)
    );

    sspc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .pop      (q_pop),
        .full     (q_full),
        .empty    (q_empty),
        .head     (q_head)
    );

    sspc_back #(
        .MAX_PARAMS (MAX_PARAMS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .store_wr (store_wr),
        .busy_clr (busy_clr),
        .out_ch   (out_ch)
    );

endmodule

>>> sim/tb_servo_status_packet_checker_top.sv
// Testbench for servo_status_packet_checker_top: drives status packets byte by byte,
// predicts every status and replayed parameter, and checks each output item in order.
// Depends on sspc_pkg, sspc_in_if, sspc_out_if and the top level.
module tb_servo_status_packet_checker_top;
    import sspc_pkg::*;

    localparam int MAX_PARAMS    = 32;
    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS   = 6;

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    typedef struct {
        status_t           status;
        logic [BYTE_W-1:0] servo_error;
        logic [BYTE_W-1:0] data_byte;
        logic              has_data;
        logic              last;
    } status_report_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    reg_idx_t              cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    sspc_in_if  in_ch();
    sspc_out_if out_ch();

    servo_status_packet_checker_top #(.MAX_PARAMS(MAX_PARAMS)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // packet tracker state and register copies
    logic [BYTE_W-1:0]   cfg_id;
    logic [PCOUNT_W-1:0] cfg_count;
    int                  pkt_pos;
    logic [BYTE_W-1:0]   sum_acc;
    logic                hdr_err;
    logic                id_err;
    logic [BYTE_W-1:0]   err_byte_q;
    logic [BYTE_W-1:0]   param_mem [MAX_PARAMS];

    status_report_t expected_reports [$];
    status_report_t head_report;

    int gap_pct;
    int stall_pct;
    int rx_hold_left;
    int items_sent;
    int mismatch_count;
    int quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int active_params();
        return (cfg_count > MAX_PARAMS) ? MAX_PARAMS : int'(cfg_count);
    endfunction

    function automatic void clear_packet();
        pkt_pos    = 0;
        sum_acc    = '0;
        hdr_err    = 1'b0;
        id_err     = 1'b0;
        err_byte_q = '0;
    endfunction

    function automatic void predict_report(op_t op, logic [BYTE_W-1:0] b);
        int             n;
        status_report_t r;
        n = active_params();
        r = '{status: ST_OK, servo_error: '0, data_byte: '0, has_data: 1'b0, last: 1'b1};
        if (op == OP_END)
        begin
            if (pkt_pos != 0)
            begin
                r.status = ST_SHORT;
                expected_reports.push_back(r);
                clear_packet();
            end
        end
        else if (pkt_pos < PARAM_POS + n)
        begin
            if (pkt_pos < ID_POS)
            begin
                if (b != HDR_BYTE)
                    hdr_err = 1'b1;
            end
            else
            begin
                if (pkt_pos == ID_POS)
                    id_err = (b != cfg_id);
                else if (pkt_pos == ERR_POS)
                    err_byte_q = b;
                else if (pkt_pos >= PARAM_POS)
                    param_mem[pkt_pos - PARAM_POS] = b;
                sum_acc = sum_acc + b;
            end
            pkt_pos++;
        end
        else
        begin
            if (hdr_err)
                r.status = ST_BAD_HEADER;
            else if (id_err)
                r.status = ST_WRONG_ID;
            else if (BYTE_W'(~sum_acc) != b)
                r.status = ST_BAD_CHECKSUM;
            if (r.status != ST_OK || n == 0)
            begin
                if (r.status == ST_OK)
                    r.servo_error = err_byte_q;
                expected_reports.push_back(r);
            end
            else
            begin
                for (int i = 0; i < n; i++)
                begin
                    r.servo_error = err_byte_q;
                    r.data_byte   = param_mem[i];
                    r.has_data    = 1'b1;
                    r.last        = (i == n - 1);
                    expected_reports.push_back(r);
                end
            end
            clear_packet();
        end
    endfunction

    task automatic set_idling(input idle_mode_t m);
        case (m)
            IDLE_NONE:     begin gap_pct = 0;  stall_pct = 0;  end
            IDLE_SENDER:   begin gap_pct = 78; stall_pct = 0;  end
            IDLE_RECEIVER: begin gap_pct = 0;  stall_pct = 78; end
            IDLE_BOTH:     begin gap_pct = 22; stall_pct = 22; end
        endcase
    endtask

    task automatic send_item(input op_t op, input logic [BYTE_W-1:0] b);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            @(negedge clk);
            in_ch.valid <= 1'b0;
        end
        @(negedge clk);
        in_ch.valid   <= 1'b1;
        in_ch.op      <= op;
        in_ch.rx_byte <= b;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        predict_report(op, b);
        items_sent++;
    endtask

    // cut > 0: send only that many bytes, then end the response
    task automatic send_frame(input logic [BYTE_W-1:0] h0, input logic [BYTE_W-1:0] h1,
                              input logic [BYTE_W-1:0] id, input logic [BYTE_W-1:0] err,
                              input int n, input logic [BYTE_W-1:0] chk_flip, input int cut);
        logic [BYTE_W-1:0] frame [$];
        logic [BYTE_W-1:0] s;
        frame = {h0, h1, id};
        frame.push_back(($urandom_range(0, 3) == 0) ? BYTE_W'($urandom_range(0, 255))
                                                    : BYTE_W'(n + 2));
        frame.push_back(err);
        repeat (n)
            frame.push_back(BYTE_W'($urandom_range(0, 255)));
        s = '0;
        for (int i = ID_POS; i < frame.size(); i++)
            s = s + frame[i];
        frame.push_back(BYTE_W'(~s) ^ chk_flip);
        if (cut > 0)
        begin
            for (int i = 0; i < cut; i++)
                send_item(OP_BYTE, frame[i]);
            send_item(OP_END, BYTE_W'($urandom_range(0, 255)));
        end
        else
        begin
            foreach (frame[i])
                send_item(OP_BYTE, frame[i]);
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_EXPECTED_ID: cfg_id    = val;
            REG_PARAM_COUNT: cfg_count = val[PCOUNT_W-1:0];
        endcase
    endtask

    task automatic configure(input logic [BYTE_W-1:0] id, input logic [PCOUNT_W-1:0] count);
        if (pkt_pos != 0)
            send_item(OP_END, BYTE_W'($urandom_range(0, 255)));
        wait_drained();
        write_reg(REG_EXPECTED_ID, id);
        write_reg(REG_PARAM_COUNT, CFG_DATA_W'(count));
    endtask

    task automatic send_random_packet();
        int                n;
        int                roll;
        int                cut;
        logic [BYTE_W-1:0] h0;
        logic [BYTE_W-1:0] h1;
        logic [BYTE_W-1:0] id;
        logic [BYTE_W-1:0] flip;
        n    = active_params();
        roll = $urandom_range(0, 99);
        h0   = HDR_BYTE;
        h1   = HDR_BYTE;
        id   = cfg_id;
        flip = '0;
        cut  = 0;
        if (roll < 60)
            ;
        else if (roll < 68)
        begin
            if ($urandom_range(0, 1))
                h0 = BYTE_W'($urandom_range(0, 255));
            else
                h1 = BYTE_W'($urandom_range(0, 255));
            if ($urandom_range(0, 1))
                id = BYTE_W'($urandom_range(0, 255));
        end
        else if (roll < 76)
        begin
            id = BYTE_W'($urandom_range(0, 255));
            if ($urandom_range(0, 1))
                flip = BYTE_W'($urandom_range(1, 255));
        end
        else if (roll < 84)
            flip = BYTE_W'($urandom_range(1, 255));
        else if (roll < 92)
            cut = $urandom_range(1, n + 5);
        if (roll < 92)
            send_frame(h0, h1, id, BYTE_W'($urandom_range(0, 255)), n, flip, cut);
        else
        begin
            // line noise, then end of response (nothing pending when no bytes went out)
            repeat ($urandom_range(0, 3))
                send_item(OP_BYTE, BYTE_W'($urandom_range(0, 255)));
            send_item(OP_END, BYTE_W'($urandom_range(0, 255)));
        end
    endtask

    task automatic test_frame_errors();
        set_idling(IDLE_NONE);
        send_frame(HDR_BYTE, HDR_BYTE, cfg_id, 8'hFF, 0, 8'h00, 0);
        send_frame(8'h00, HDR_BYTE, 8'h00, 8'h00, 0, 8'h00, 0);
        send_frame(HDR_BYTE, 8'hFE, cfg_id, 8'h00, 0, 8'h00, 0);
        send_frame(HDR_BYTE, HDR_BYTE, 8'h02, 8'h00, 0, 8'h01, 0);
        send_frame(HDR_BYTE, HDR_BYTE, cfg_id, 8'h00, 0, 8'h80, 0);
        send_frame(HDR_BYTE, HDR_BYTE, cfg_id, 8'h55, 0, 8'h00, 3);
        send_item(OP_END, 8'h00);
    endtask

    task automatic test_param_replay();
        configure(8'hFF, 6'd1);
        send_frame(HDR_BYTE, HDR_BYTE, 8'hFF, 8'h00, 1, 8'h00, 0);
        configure(8'h00, 6'd2);
        send_frame(HDR_BYTE, HDR_BYTE, 8'h00, 8'hA5, 2, 8'h00, 0);
    endtask

    task automatic test_random_traffic();
        int                  start;
        logic [BYTE_W-1:0]   id;
        logic [PCOUNT_W-1:0] count;
        idle_mode_t          m;
        for (int p = 0; p < 3; p++)
        begin
            id = BYTE_W'($urandom_range(0, 255));
            case (p)
                0: begin count = 6'd3;  m = IDLE_SENDER;   id = 8'h00; end
                1: begin count = 6'd1;  m = IDLE_RECEIVER; id = 8'hFF; end
                2: begin count = 6'd63; m = IDLE_BOTH;     end
                default: begin count = 6'd0; m = IDLE_NONE; end
            endcase
            configure(id, count);
            set_idling(m);
            start = items_sent;
            while (items_sent - start < PHASE_ITEMS)
                send_random_packet();
        end
    endtask

    // output held off while the sender keeps offering, so the input backs up
    task automatic test_output_backpressure();
        configure(BYTE_W'($urandom_range(0, 255)), 6'd3);
        set_idling(IDLE_NONE);
        rx_hold_left = 300;
        repeat (3)
            send_frame(HDR_BYTE, HDR_BYTE, cfg_id, BYTE_W'($urandom_range(0, 255)), 3, 8'h00, 0);
        wait_drained();
    endtask

    task automatic check_field(input string name, input logic [BYTE_W-1:0] exp_v,
                               input logic [BYTE_W-1:0] got_v);
        if (got_v !== exp_v)
        begin
            $error("%s: expected %0h, got %0h", name, exp_v, got_v);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_reports.size() == 0)
            begin
                $error("status: expected no item, got %0d", out_ch.status);
                mismatch_count++;
            end
            else
            begin
                head_report = expected_reports.pop_front();
                check_field("status", BYTE_W'(head_report.status), BYTE_W'(out_ch.status));
                check_field("servo_error", head_report.servo_error, out_ch.servo_error);
                check_field("data_byte", head_report.data_byte, out_ch.data_byte);
                check_field("has_data", BYTE_W'(head_report.has_data), BYTE_W'(out_ch.has_data));
                check_field("last", BYTE_W'(head_report.last), BYTE_W'(out_ch.last));
            end
        end
    end

    always @(negedge clk)
    begin
        if (rx_hold_left > 0)
        begin
            out_ch.ready <= 1'b0;
            rx_hold_left--;
        end
        else
            out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet_cycles = 0;
            else if (++quiet_cycles >= STALL_LIMIT)
            begin
                $display("** servo_status_packet_checker_top: FAILED **");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = REG_EXPECTED_ID;
        cfg_wdata      = '0;
        in_ch.valid    = 1'b0;
        in_ch.op       = OP_BYTE;
        in_ch.rx_byte  = '0;
        out_ch.ready   = 1'b0;
        gap_pct        = 0;
        stall_pct      = 0;
        rx_hold_left   = 0;
        items_sent     = 0;
        mismatch_count = 0;
        quiet_cycles   = 0;
        cfg_id         = 8'd1;
        cfg_count      = '0;
        clear_packet();
        repeat (3)
            @(negedge clk);
        rst_n = 1'b1;

        test_frame_errors();
        test_param_replay();
        test_random_traffic();
        test_output_backpressure();

        wait_drained();
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        if (mismatch_count == 0 && expected_reports.size() == 0)
            $display("** servo_status_packet_checker_top: PASSED **");
        else
            $display("** servo_status_packet_checker_top: FAILED **");
        $finish;
    end

endmodule
